/* src/tsq_pkg.sv */
package tsq_pkg;

   localparam int FRAME_W   = 31;
   localparam int PAYLOAD_W = 32;
   localparam int HELD_W    = 7;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_PULL   = 1'b1;

   typedef struct packed {
      logic                 command;
      logic [FRAME_W-1:0]   release_frame;
      logic [PAYLOAD_W-1:0] entry_payload;
      logic [FRAME_W-1:0]   current_frame;
   } req_type;

   typedef struct packed {
      logic                 released;
      logic [PAYLOAD_W-1:0] released_payload;
      logic                 insert_dropped;
      logic [HELD_W-1:0]    entries_held;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_W-1:0]   frame;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_PULL,
      ST_DONE
   } state_type;

endpackage

/* src/timed_release_sorted_queue_core.sv */
// An insert walks down from the tail: each held entry with a later frame is moved
// up one slot while the slot below it is read, then the new entry is written.
// A pull reads the head entry; a dropped insert or an empty pull goes to the response.
// An item is accepted in the cycle after its predecessor's response is loaded, so
// the block holds one item at a time and the insertion walk sets the worst case.
// Reset clears the head, count and handshake state; store contents stay undefined.
module timed_release_sorted_queue_core #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(off);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   tsq_pkg::state_type state_ff, state_in;
   logic                            cmd_ff, cmd_in;
   logic [tsq_pkg::FRAME_W-1:0]     frame_ff, frame_in;
   logic [tsq_pkg::PAYLOAD_W-1:0]   payload_ff, payload_in;
   logic [tsq_pkg::FRAME_W-1:0]     now_ff, now_in;
   logic [CNT_W-1:0]                pos_ff, pos_in;
   logic [IDX_W-1:0]                head_ff, head_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            rel_ff, rel_in;
   logic [tsq_pkg::PAYLOAD_W-1:0]   relpay_ff, relpay_in;
   logic                            drop_ff, drop_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   tsq_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   tsq_pkg::entry_type  wr_entry;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   tsq_pkg::entry_type  rd_entry;

   logic req_accept;
   logic store_full;
   logic store_empty;
   logic scan_later;
   logic pull_due;
   logic rsp_free;

   tsq_store #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   assign req_stall   = (state_ff != tsq_pkg::ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign store_full  = (count_ff == CNT_W'(CAPACITY));
   assign store_empty = (count_ff == '0);
   assign scan_later  = (rd_entry.frame > frame_ff);
   assign pull_due    = (rd_entry.frame <= now_ff);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsq_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_data.command == tsq_pkg::CMD_INSERT) begin
                  if (store_full) begin
                     state_in = tsq_pkg::ST_DONE;
                  end else if (store_empty) begin
                     state_in = tsq_pkg::ST_PLACE;
                  end else begin
                     state_in = tsq_pkg::ST_SCAN;
                  end
               end else if (store_empty) begin
                  state_in = tsq_pkg::ST_DONE;
               end else begin
                  state_in = tsq_pkg::ST_PULL;
               end
            end
         end
         tsq_pkg::ST_SCAN: begin
            if (!scan_later) begin
               state_in = tsq_pkg::ST_DONE;
            end else if (pos_ff == CNT_W'(1)) begin
               state_in = tsq_pkg::ST_PLACE;
            end
         end
         tsq_pkg::ST_PLACE: state_in = tsq_pkg::ST_DONE;
         tsq_pkg::ST_PULL:  state_in = tsq_pkg::ST_DONE;
         tsq_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = tsq_pkg::ST_IDLE;
            end
         end
         default: state_in = tsq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      frame_in     = frame_ff;
      payload_in   = payload_ff;
      now_in       = now_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rel_in       = rel_ff;
      relpay_in    = relpay_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_of(head_ff, pos_ff);
      wr_entry     = '{frame: frame_ff, payload: payload_ff};
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      case (state_ff)
         tsq_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in     = req_data.command;
               frame_in   = req_data.release_frame;
               payload_in = req_data.entry_payload;
               now_in     = req_data.current_frame;
               pos_in     = count_ff;
               rel_in     = 1'b0;
               relpay_in  = '0;
               drop_in    = (req_data.command == tsq_pkg::CMD_INSERT) && store_full;
               if (!store_empty && !(req_data.command == tsq_pkg::CMD_INSERT && store_full))
               begin
                  rd_en = 1'b1;
                  if (req_data.command == tsq_pkg::CMD_INSERT) begin
                     rd_addr = slot_of(head_ff, count_ff - CNT_W'(1));
                  end
               end
            end
         end
         tsq_pkg::ST_SCAN: begin
            // The slot two below pos is read while the later entry from the slot below
            // moves up into pos, so the read and the shift overlap.
            wr_en = 1'b1;
            if (scan_later) begin
               wr_entry = rd_entry;
               pos_in   = pos_ff - CNT_W'(1);
               if (pos_ff != CNT_W'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = slot_of(head_ff, pos_ff - CNT_W'(2));
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         tsq_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         tsq_pkg::ST_PULL: begin
            if (pull_due) begin
               rel_in    = 1'b1;
               relpay_in = rd_entry.payload;
               head_in   = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + IDX_W'(1);
               count_in  = count_ff - CNT_W'(1);
            end
         end
         tsq_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.released         = rel_ff;
               rsp_data_in.released_payload = relpay_ff;
               rsp_data_in.insert_dropped   = drop_ff;
               rsp_data_in.entries_held     = tsq_pkg::HELD_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      frame_ff    <= frame_in;
      payload_ff  <= payload_in;
      now_ff      <= now_in;
      pos_ff      <= pos_in;
      rel_ff      <= rel_in;
      relpay_ff   <= relpay_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The count never passes the store depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // An insert into a full store goes straight to the response with the drop flag.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.command == tsq_pkg::CMD_INSERT && store_full
      |=> state_ff == tsq_pkg::ST_DONE && drop_ff && !rel_ff)
      else $error("full-store insert not dropped");

   // A due pull removes exactly one entry and advances the head.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == tsq_pkg::ST_PULL && pull_due
      |=> count_ff == $past(count_ff) - CNT_W'(1) && head_ff != $past(head_ff))
      else $error("pull did not remove the head entry");

   // Only an insert moves through the walk states.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsq_pkg::ST_SCAN || state_ff == tsq_pkg::ST_PLACE)
      |-> cmd_ff == tsq_pkg::CMD_INSERT && !store_full)
      else $error("walk state entered without a pending insert");
`endif

endmodule

/* src/tsq_store.sv */
module tsq_store #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  tsq_pkg::entry_type  wr_entry,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output tsq_pkg::entry_type  rd_entry
);

   tsq_pkg::entry_type mem_ff [DEPTH];
   tsq_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule
